[src/pwmc_pkg.sv]
// pwmc_pkg: shared widths, reset values and capture phase codes for the
// pwm period/duty capture block; no dependencies
`timescale 1ns / 1ps

package pwmc_pkg;

  // fixed field widths
  localparam int CAP_W  = 32;   // capture value and tick count ports
  localparam int CLK_W  = 28;   // counter clock and frequency
  localparam int DUTY_W = 14;   // duty in hundredths of a percent

  // default counter width of the capture timer
  localparam int COUNTER_WIDTH_DEF = 32;

  // full scale duty, also the multiplier for the duty dividend
  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

  // counter clock after reset
  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 28'd60000000;

  // capture phase codes
  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_RISE2 = 2'd1,
    PH_FALL  = 2'd2,
    PH_SPARE = 2'd3
  } phase_t;

endpackage

[src/pwmc_divstep.sv]
// pwmc_divstep: one restoring division step, shared by the frequency and
// duty divisions; depends on nothing
`timescale 1ns / 1ps

module pwmc_divstep #(
  parameter int W = 32
) (
  input  logic [W-1:0] rem_in,
  input  logic         dvd_bit,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] rem_out,
  output logic         q_bit
);

  logic [W:0] shifted;
  logic [W:0] trial;

  // shift in the next dividend bit and try the subtraction
  assign shifted = {rem_in, dvd_bit};
  assign trial   = shifted - {1'b0, divisor};
  assign q_bit   = (shifted >= {1'b0, divisor});
  assign rem_out = q_bit ? trial[W-1:0] : shifted[W-1:0];

endmodule

[src/pwm_period_duty_capture_core.sv]
// pwm_period_duty_capture_core: input capture sequencer with period, high
// time, frequency and duty results; uses pwmc_pkg and pwmc_divstep
`timescale 1ns / 1ps

//  channel | ports                          | handshake
//  --------+--------------------------------+----------------------
//  input   | in_capture_value               | in_valid / in_ready
//  result  | out_* fields                   | out_valid / out_ready
//  config  | cfg_wr_data (counter clock hz) | cfg_wr_en, no wait
//
// A first or second rise capture is accepted in idle; its result is registered
// the cycle after. A fall capture runs a multiply state, 28 steps of the
// shared divide unit for frequency, 14 more for duty and a load state that
// waits for a free result register; the duty steps are skipped when the duty
// saturates, and both divisions are skipped when the period is zero.
// in_ready is high only while the sequencer idles and the result register is
// free or being drained. Synchronous active-low reset, no clearing pass.

module pwm_period_duty_capture_core
  import pwmc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // capture items
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CAP_W-1:0]  in_capture_value,
  // result items
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_next_edge_falling,
  output logic              out_measurement_valid,
  output logic [CAP_W-1:0]  out_period_ticks,
  output logic [CAP_W-1:0]  out_high_ticks,
  output logic [CLK_W-1:0]  out_frequency_hz,
  output logic [DUTY_W-1:0] out_duty_hundredths,
  output logic              out_zero_period,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [CLK_W-1:0]  cfg_wr_data
);

  localparam int CW    = COUNTER_WIDTH;
  localparam int PW    = CW + DUTY_W;
  localparam int CNT_W = $clog2(CLK_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FREQ = 5'b00100,
    ST_DUTY = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [CLK_W-1:0]    clk_hz_r;
  logic [CW-1:0]       first_rise_r, first_rise_nxt;
  logic [CW-1:0]       second_rise_r, second_rise_nxt;
  logic [CW-1:0]       period_r, period_nxt;
  logic [CW-1:0]       high_r, high_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic                sat_r, sat_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic [CLK_W-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CLK_W-1:0]    freq_r, freq_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_fall_r, out_fall_nxt;
  logic                out_meas_r, out_meas_nxt;
  logic [CW-1:0]       out_period_r, out_period_nxt;
  logic [CW-1:0]       out_high_r, out_high_nxt;
  logic [CLK_W-1:0]    out_freq_r, out_freq_nxt;
  logic [DUTY_W-1:0]   out_duty_r, out_duty_nxt;
  logic                out_zero_r, out_zero_nxt;

  logic [CW-1:0]       cap;
  logic                out_free;
  logic                in_fire;
  logic [CW-1:0]       step_rem;
  logic                step_q;

  assign cap      = in_capture_value[CW-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // shared divide step: remainder, next dividend bit from the top of dvd_r
  pwmc_divstep #(
    .W (CW)
  ) u_divstep (
    .rem_in  (rem_r),
    .dvd_bit (dvd_r[CLK_W-1]),
    .divisor (period_r),
    .rem_out (step_rem),
    .q_bit   (step_q)
  );

  // sequencer and datapath
  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    first_rise_nxt  = first_rise_r;
    second_rise_nxt = second_rise_r;
    period_nxt      = period_r;
    high_nxt        = high_r;
    prod_nxt        = prod_r;
    sat_nxt         = sat_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    cnt_nxt         = cnt_r;
    freq_nxt        = freq_r;
    duty_nxt        = duty_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_fall_nxt    = out_fall_r;
    out_meas_nxt    = out_meas_r;
    out_period_nxt  = out_period_r;
    out_high_nxt    = out_high_r;
    out_freq_nxt    = out_freq_r;
    out_duty_nxt    = out_duty_r;
    out_zero_nxt    = out_zero_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (phase_r)
            PH_RISE2: begin
              second_rise_nxt = cap;
              period_nxt      = cap - first_rise_r;
              phase_nxt       = PH_FALL;
              out_valid_nxt   = 1'b1;
              out_fall_nxt    = 1'b1;
              out_meas_nxt    = 1'b0;
              out_period_nxt  = '0;
              out_high_nxt    = '0;
              out_freq_nxt    = '0;
              out_duty_nxt    = '0;
              out_zero_nxt    = 1'b0;
            end
            PH_FALL: begin
              high_nxt  = cap - second_rise_r;
              state_nxt = ST_MUL;
            end
            default: begin
              // first rise, and the spare code treated the same way
              first_rise_nxt = cap;
              phase_nxt      = PH_RISE2;
              out_valid_nxt  = 1'b1;
              out_fall_nxt   = 1'b0;
              out_meas_nxt   = 1'b0;
              out_period_nxt = '0;
              out_high_nxt   = '0;
              out_freq_nxt   = '0;
              out_duty_nxt   = '0;
              out_zero_nxt   = 1'b0;
            end
          endcase
        end
      end
      ST_MUL: begin
        // duty dividend and saturation check, then start the frequency divide unless the period is zero
        prod_nxt = PW'(high_r) * PW'(DUTY_FULL);
        sat_nxt  = (high_r >= period_r);
        freq_nxt = '0;
        duty_nxt = '0;
        if (period_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = clk_hz_r;
          cnt_nxt   = CNT_W'(CLK_W - 1);
          state_nxt = ST_FREQ;
        end
      end
      ST_FREQ: begin
        rem_nxt = step_rem;
        dvd_nxt = {dvd_r[CLK_W-2:0], step_q};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          freq_nxt = {dvd_r[CLK_W-2:0], step_q};
          if (sat_r) begin
            duty_nxt  = DUTY_FULL;
            state_nxt = ST_DONE;
          end else begin
            // quotient below full scale, so the upper part is already < period
            rem_nxt   = prod_r[PW-1:DUTY_W];
            dvd_nxt   = {prod_r[DUTY_W-1:0], {(CLK_W - DUTY_W){1'b0}}};
            cnt_nxt   = CNT_W'(DUTY_W - 1);
            state_nxt = ST_DUTY;
          end
        end
      end
      ST_DUTY: begin
        rem_nxt = step_rem;
        dvd_nxt = {dvd_r[CLK_W-2:0], step_q};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          duty_nxt  = {dvd_r[DUTY_W-2:0], step_q};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_fall_nxt   = 1'b0;
          out_meas_nxt   = 1'b1;
          out_period_nxt = period_r;
          out_high_nxt   = high_r;
          out_freq_nxt   = freq_r;
          out_duty_nxt   = duty_r;
          out_zero_nxt   = (period_r == '0);
          phase_nxt      = PH_RISE1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_RISE1;
      first_rise_r  <= '0;
      second_rise_r <= '0;
      period_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      first_rise_r  <= first_rise_nxt;
      second_rise_r <= second_rise_nxt;
      period_r      <= period_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // counter clock register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    high_r       <= high_nxt;
    prod_r       <= prod_nxt;
    sat_r        <= sat_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    cnt_r        <= cnt_nxt;
    freq_r       <= freq_nxt;
    duty_r       <= duty_nxt;
    out_fall_r   <= out_fall_nxt;
    out_meas_r   <= out_meas_nxt;
    out_period_r <= out_period_nxt;
    out_high_r   <= out_high_nxt;
    out_freq_r   <= out_freq_nxt;
    out_duty_r   <= out_duty_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_next_edge_falling = out_fall_r;
  assign out_measurement_valid = out_meas_r;
  assign out_period_ticks      = CAP_W'(out_period_r);
  assign out_high_ticks        = CAP_W'(out_high_r);
  assign out_frequency_hz      = out_freq_r;
  assign out_duty_hundredths   = out_duty_r;
  assign out_zero_period       = out_zero_r;

  // a fall capture always starts the multiply cycle
  a_fall_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_FALL) |=> (state_r == ST_MUL))
    else $error("fall capture did not start the measurement");

  // a completed measurement always asks for a rising edge next
  a_meas_next_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_meas_r) |-> !out_fall_r)
    else $error("measurement result asks for a falling edge");

  // zero period gives zero frequency and duty
  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (out_freq_r == '0 && out_duty_r == '0))
    else $error("zero period with nonzero frequency or duty");

  // duty stays within full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r <= DUTY_FULL))
    else $error("duty above full scale");

endmodule
